>>> src/mbps_pkg.sv
// Shared constants and register indexes for the masked byte pattern search core.
package mbps_pkg;

    localparam int MAX_PATTERN   = 16;
    localparam int OFFSET_WIDTH  = 32;
    localparam int LEN_W         = 5;
    localparam int CFG_W         = 64;
    localparam int CFG_IDX_W     = 3;
    localparam int BYTE_W        = 8;
    localparam int MATCH_OFS_W   = 32;
    localparam int WIN_IDX_W     = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CARE_LOW       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CARE_HIGH      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd4;

    typedef logic [BYTE_W-1:0] t_byte;

endpackage

>>> src/masked_byte_pattern_search_core.sv
// Masked byte pattern search core: window compare over a byte stream, first match per frame.
// Latency: a result is valid in the cycle after the input transfer that causes it.
// Throughput: one byte per cycle when not stalled; set by the parallel masked window compare.
// The input stays ready while the output register is empty or being drained.
// Reset (synchronous, active low) clears configuration, window, byte count,
// match flag and the output valid.
module masked_byte_pattern_search_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mbps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mbps_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // [7:0] data_byte
    input  logic                              s_axis_tlast,   // last_byte
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [31:0]                       m_axis_tdata,   // [31:0] match_offset
    output logic                              m_axis_tuser    // [0] found
);
    import mbps_pkg::*;

    logic [CFG_W-1:0]        r_pattern_low;
    logic [CFG_W-1:0]        r_pattern_high;
    logic [CFG_W-1:0]        r_care_low;
    logic [CFG_W-1:0]        r_care_high;
    logic [LEN_W-1:0]        r_pattern_length;

    t_byte                   r_window [MAX_PATTERN];
    t_byte                   n_window [MAX_PATTERN];
    logic [OFFSET_WIDTH-1:0] r_count;
    logic [OFFSET_WIDTH-1:0] n_count;
    logic                    r_matched;

    logic                    r_out_valid;
    logic                    r_out_found;
    logic [MATCH_OFS_W-1:0]  r_out_offset;

    logic [2*CFG_W-1:0]      pattern_all;
    logic [2*CFG_W-1:0]      care_all;
    logic [LEN_W-1:0]        len_eff;
    logic [MAX_PATTERN-1:0]  lane_ok;
    logic                    in_xfer;
    logic                    match;
    logic                    emit;
    logic [OFFSET_WIDTH-1:0] offset_full;

    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !r_out_valid || m_axis_tready;

    assign pattern_all = {r_pattern_high, r_pattern_low};
    assign care_all    = {r_care_high, r_care_low};
    assign len_eff     = (r_pattern_length > LEN_W'(MAX_PATTERN)) ?
                         LEN_W'(MAX_PATTERN) : r_pattern_length;

    // Shifted window with the incoming byte as newest entry.
    always_comb begin
        for (int k = 0; k < MAX_PATTERN - 1; k++) begin
            n_window[k] = r_window[k + 1];
        end
        n_window[MAX_PATTERN - 1] = s_axis_tdata;
    end

    assign n_count = (r_count == {OFFSET_WIDTH{1'b1}}) ? r_count : r_count + 1'b1;

    // Pattern byte i lines up with window entry MAX_PATTERN - len + i.
    always_comb begin
        logic [LEN_W-1:0]     pos;
        logic [WIN_IDX_W-1:0] idx;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            pos = LEN_W'(MAX_PATTERN) - len_eff + LEN_W'(i);
            idx = pos[WIN_IDX_W-1:0];
            if (LEN_W'(i) < len_eff) begin
                lane_ok[i] = ((n_window[idx] & care_all[BYTE_W*i +: BYTE_W])
                              == pattern_all[BYTE_W*i +: BYTE_W]);
            end else begin
                lane_ok[i] = 1'b1;
            end
        end
    end

    assign match = !r_matched && (len_eff != '0) &&
                   (n_count >= OFFSET_WIDTH'(len_eff)) && (&lane_ok);
    assign emit  = match || (s_axis_tlast && !r_matched);
    assign offset_full = n_count - OFFSET_WIDTH'(len_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_low    <= '0;
            r_pattern_high   <= '0;
            r_care_low       <= '0;
            r_care_high      <= '0;
            r_pattern_length <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PATTERN_LOW:    r_pattern_low    <= i_cfg_data;
                CFG_PATTERN_HIGH:   r_pattern_high   <= i_cfg_data;
                CFG_CARE_LOW:       r_care_low       <= i_cfg_data;
                CFG_CARE_HIGH:      r_care_high      <= i_cfg_data;
                CFG_PATTERN_LENGTH: r_pattern_length <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
                r_window[k] <= '0;
            end
            r_count   <= '0;
            r_matched <= 1'b0;
        end else if (in_xfer) begin
            if (s_axis_tlast) begin
                // end of frame: restart the search
                for (int k = 0; k < MAX_PATTERN; k++) begin
                    r_window[k] <= '0;
                end
                r_count   <= '0;
                r_matched <= 1'b0;
            end else begin
                r_window  <= n_window;
                r_count   <= n_count;
                r_matched <= r_matched || match;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= emit;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && emit) begin
            r_out_found  <= match;
            r_out_offset <= match ? MATCH_OFS_W'(offset_full) : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_offset;
    assign m_axis_tuser  = r_out_found;

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && s_axis_tlast) |=> (r_count == '0 && !r_matched))
        else $error("search state not cleared after end of frame");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("not-found result carries a nonzero offset");

    a_match_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && match && !s_axis_tlast) |=> r_matched)
        else $error("match flag not set after a reported match");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with an empty output register");

endmodule
